// ===== hdl/bdag_pkg.sv =====
`timescale 1ns / 1ps

package bdag_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_WALK,
        S_EMIT,
        S_ERROR
    } state_t;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t REG_SEPARATOR   = 1'b0;
    localparam cfg_idx_t REG_BUFFER_SIZE = 1'b1;

    localparam logic [7:0] SEPARATOR_RESET   = 8'd46;
    localparam logic [7:0] BUFFER_SIZE_RESET = 8'd16;
    localparam logic [7:0] ASCII_ZERO        = 8'h30;
    localparam logic [7:0] MIN_BUFFER_SIZE   = 8'd2;
    localparam logic [1:0] GROUP_LEN         = 2'd3;
    localparam logic [3:0] DABBLE_LIMIT      = 4'd5;
    localparam logic [3:0] DABBLE_ADD        = 4'd3;

endpackage

// ===== hdl/binary_to_decimal_ascii_grouped.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// request   req_valid / req_stall     value
// result    res_valid / res_stall     character, last, too_small
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A value passes through the shift-add-3 unit (two bits a cycle), then is laid
// into the scratch buffer one character per cycle, then leaves one character
// per cycle out of its single read port while res_stall allows; at 32 bits
// the text has at most 13 characters.
// A buffer size below 2 gives the error result by way of the error state.
// req_stall is high from the accepted request until the last character has
// entered the output register; res_stall holds the output register.
// Reset loads separator 46 and buffer size 16; no clearing pass is needed.

module binary_to_decimal_ascii_grouped
    import bdag_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [7:0]             character,
    output logic                   last,
    output logic                   too_small,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_idx_t               cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam int PW     = VALUE_WIDTH + (VALUE_WIDTH % 2);
    localparam int STEPS  = PW / 2;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int NDIG   = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int SDEPTH = NDIG + (NDIG - 1) / 3;
    localparam int IDX_W  = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CNT_W  = $clog2(SDEPTH + 1);

    state_t             state_reg, state_next;
    logic [PW-1:0]      val_reg, val_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [7:0]         slots_reg, slots_next;
    logic [1:0]         group_reg, group_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]   rd_reg, rd_next;
    logic [7:0]         sep_reg, bsize_reg;
    logic [7:0]         scratch [SDEPTH];

    logic               res_valid_reg, res_valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               small_reg, small_next;

    logic               req_take;
    logic               out_free;
    logic               walk_done;
    logic               put_sep;
    logic               wr_en;
    logic [7:0]         wr_char;
    logic [BCD_W-1:0]   dabble;

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign too_small = small_reg;

    assign walk_done = ((bcd_reg == '0) && (n_reg != '0)) || (slots_reg == 8'd0);
    assign put_sep   = (sep_reg != 8'd0) && (group_reg == GROUP_LEN) && (slots_reg > 8'd1);

    // shift-add-3 unit: two bits a cycle
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [PW-1:0]    v;
        b = bcd_reg;
        v = val_reg;
        for (int s = 0; s < 2; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (b[d*4 +: 4] >= DABBLE_LIMIT)
                begin
                    b[d*4 +: 4] = b[d*4 +: 4] + DABBLE_ADD;
                end
            end
            b = {b[BCD_W-2:0], v[PW-1]};
            v = {v[PW-2:0], 1'b0};
        end
        dabble = b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (bsize_reg < MIN_BUFFER_SIZE) ? S_ERROR : S_CONV;
                end
            end
            S_CONV:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free && (rd_reg == '0))
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERROR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        val_next       = val_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        slots_next     = slots_reg;
        group_next     = group_reg;
        n_next         = n_reg;
        rd_next        = rd_reg;
        wr_en          = 1'b0;
        wr_char        = ASCII_ZERO | {4'd0, bcd_reg[3:0]};
        res_valid_next = res_valid_reg && res_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        small_next     = small_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    val_next   = PW'(value);
                    bcd_next   = '0;
                    step_next  = STEP_W'(STEPS - 1);
                    slots_next = bsize_reg - 8'd1;
                    group_next = 2'd0;
                    n_next     = '0;
                end
            end
            S_CONV:
            begin
                bcd_next  = dabble;
                val_next  = {val_reg[PW-3:0], 2'b00};
                step_next = step_reg - STEP_W'(1);
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    rd_next = IDX_W'(n_reg - CNT_W'(1));
                end
                else
                begin
                    wr_en      = 1'b1;
                    n_next     = n_reg + CNT_W'(1);
                    slots_next = slots_reg - 8'd1;
                    if (put_sep)
                    begin
                        wr_char    = sep_reg;
                        group_next = 2'd0;
                    end
                    else
                    begin
                        bcd_next   = {4'd0, bcd_reg[BCD_W-1:4]};
                        group_next = (group_reg == GROUP_LEN) ? group_reg : group_reg + 2'd1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    char_next      = scratch[rd_reg];
                    last_next      = (rd_reg == '0);
                    small_next     = 1'b0;
                    rd_next        = rd_reg - IDX_W'(1);
                end
            end
            S_ERROR:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    char_next      = 8'd0;
                    last_next      = 1'b1;
                    small_next     = 1'b1;
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            sep_reg       <= SEPARATOR_RESET;
            bsize_reg     <= BUFFER_SIZE_RESET;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            n_reg         <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEPARATOR:   sep_reg   <= cfg_data;
                    REG_BUFFER_SIZE: bsize_reg <= cfg_data;
                    default:         sep_reg   <= sep_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        bcd_reg   <= bcd_next;
        step_reg  <= step_next;
        slots_reg <= slots_next;
        group_reg <= group_next;
        rd_reg    <= rd_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        small_reg <= small_next;
        if (wr_en)
        begin
            scratch[n_reg[IDX_W-1:0]] <= wr_char;
        end
    end

`ifndef SYNTHESIS
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted without leaving idle");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && small_reg |-> last_reg && (char_reg == 8'd0))
        else $error("error result not a lone zero character");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(SDEPTH))
        else $error("scratch buffer overrun");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> n_reg != '0)
        else $error("emitting an empty text");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_free && rd_reg == '0 |=> state_reg == S_IDLE)
        else $error("last character did not end the value");
`endif

endmodule
